// ===== sv/ipst_pkg.sv =====
`timescale 1ns / 1ps
package ipst_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 24;
    localparam int SUM_WIDTH    = 40;
    localparam int PROD_WIDTH   = 40;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 24;
    localparam int NUM_PATTERNS = 7;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SKIP  = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PROBE = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SUPPLY = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_VTOL  = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CTOL  = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DUTY  = 3'd5;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_NO_MOTOR = 2'd1,
        VERDICT_FAULT    = 2'd2,
        VERDICT_OVERCURR = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TEST = 2'd1,
        MODE_HALT = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_DRIVE  = 3'd1,
        PH_SETTLE = 3'd2,
        PH_PROBE  = 3'd3,
        PH_CLASS  = 3'd4,
        PH_JUDGE  = 3'd5
    } phase_t;

    // Sequencer of the top level: accepting, the serial classifier, presenting a result.
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_CLASS  = 2'd1,
        ST_OUTPUT = 2'd2
    } ctrl_t;

    typedef struct packed {
        logic                           kind;
        logic signed [SAMPLE_WIDTH-1:0] volt_a;
        logic signed [SAMPLE_WIDTH-1:0] volt_b;
        logic signed [SAMPLE_WIDTH-1:0] volt_c;
        logic signed [SAMPLE_WIDTH-1:0] curr_a;
        logic signed [SAMPLE_WIDTH-1:0] curr_b;
    } in_item_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  float_mask;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  verdict;
    } out_item_t;

    function automatic logic [2:0] pat_mask(input logic [2:0] idx);
        logic [2:0] m;
        case (idx)
            3'd0:          m = 3'd7;
            3'd1, 3'd2:    m = 3'd6;
            3'd3, 3'd4:    m = 3'd5;
            default:       m = 3'd3;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/ipst_classify.sv =====
`timescale 1ns / 1ps
module ipst_classify (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [ipst_pkg::SUM_WIDTH-1:0] sum_a,
    input  logic signed [ipst_pkg::SUM_WIDTH-1:0] sum_b,
    input  logic signed [ipst_pkg::SUM_WIDTH-1:0] sum_c,
    input  logic [ipst_pkg::COUNT_WIDTH-1:0]  n,
    input  logic [14:0]                       supply,
    input  logic [14:0]                       vtol,
    output logic                              done,
    output logic [6:0]                        code
);
    import ipst_pkg::*;

    // Shift-and-add multiply of supply*n and vtol*n, one bit of n per cycle,
    // then one phase compared per cycle.
    localparam int CNT_W = $clog2(COUNT_WIDTH + 4);

    logic [COUNT_WIDTH-1:0] n_reg, n_next;
    logic [PROD_WIDTH-1:0]  sup_reg, sup_next, band_reg, band_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic [6:0]             code_reg, code_next;

    logic signed [SUM_WIDTH-1:0] cur_sum;
    logic signed [SUM_WIDTH+1:0] dh, dl, adh, adl;
    logic [1:0]                  ph;
    logic [PROD_WIDTH-1:0]       sup_sh, vt_sh;

    always_comb begin
        ph = 2'(cnt_reg - CNT_W'(COUNT_WIDTH));
        case (ph)
            2'd0:    cur_sum = sum_a;
            2'd1:    cur_sum = sum_b;
            default: cur_sum = sum_c;
        endcase
        dh  = (SUM_WIDTH+2)'(cur_sum) - $signed({2'b00, sup_reg});
        dl  = (SUM_WIDTH+2)'(cur_sum);
        adh = dh[SUM_WIDTH+1] ? -dh : dh;
        adl = dl[SUM_WIDTH+1] ? -dl : dl;
        sup_sh = PROD_WIDTH'(supply) << cnt_reg;
        vt_sh  = PROD_WIDTH'(vtol) << cnt_reg;
    end

    always_comb begin
        busy_next = busy_reg;
        n_next    = n_reg;
        sup_next  = sup_reg;
        band_next = band_reg;
        cnt_next  = cnt_reg;
        code_next = code_reg;
        done      = 1'b0;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                n_next    = n;
                sup_next  = '0;
                band_next = '0;
                cnt_next  = '0;
                code_next = '0;
            end
        end else if (cnt_reg < CNT_W'(COUNT_WIDTH)) begin
            if (n_reg[0]) begin
                sup_next  = sup_reg + sup_sh;
                band_next = band_reg + vt_sh;
            end
            n_next   = n_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
        end else begin
            if (adh < $signed({2'b00, band_reg}))
                code_next[ph] = 1'b1;
            else if (!(adl < $signed({2'b00, band_reg})))
                code_next[3'd4 + 3'(ph)] = 1'b1;
            cnt_next = cnt_reg + 1'b1;
            if (ph == 2'd2) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        n_reg    <= n_next;
        sup_reg  <= sup_next;
        band_reg <= band_next;
        code_reg <= code_next;
    end

    assign code = code_next;

endmodule

// ===== sv/inverter_power_stage_self_test.sv =====
`timescale 1ns / 1ps
// Channel    Ports            Payload
// input      s_valid/s_ready  s_data  (kind, volt_a..c, curr_a..b)
// result     m_valid/m_ready  m_data  (duty_a..c, float_mask, busy, done, verdict)
// config     cfg_we           cfg_addr, cfg_wdata
// An accepted transaction's result is registered and shown in ST_OUTPUT; a test
// tick of phase PH_CLASS first runs the classifier (24-bit multiply, 3 compares).
// Reset is synchronous on aresetn and restores the register defaults.
// While a result waits for m_ready, no new transaction is accepted.
module inverter_power_stage_self_test (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  ipst_pkg::in_item_t                      s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output ipst_pkg::out_item_t                     m_data,
    input  logic                                    cfg_we,
    input  logic [ipst_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr,
    input  logic [ipst_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata
);
    import ipst_pkg::*;

    logic [COUNT_WIDTH-1:0] skip_reg, probe_reg;
    logic [14:0] supply_reg, vtol_reg, ctol_reg;
    logic [15:0] full_duty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg      <= COUNT_WIDTH'(1000);
            probe_reg     <= COUNT_WIDTH'(4000);
            supply_reg    <= 15'd12000;
            vtol_reg      <= 15'd1000;
            ctol_reg      <= 15'd20000;
            full_duty_reg <= 16'd2000;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SKIP:   skip_reg      <= cfg_wdata[COUNT_WIDTH-1:0];
                REG_PROBE:  probe_reg     <= cfg_wdata[COUNT_WIDTH-1:0];
                REG_SUPPLY: supply_reg    <= cfg_wdata[14:0];
                REG_VTOL:   vtol_reg      <= cfg_wdata[14:0];
                REG_CTOL:   ctol_reg      <= cfg_wdata[14:0];
                REG_DUTY:   full_duty_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    ctrl_t  ctrl_reg, ctrl_next;
    mode_t  mode_reg, mode_next;
    phase_t phase_reg, phase_next;
    logic [2:0] pidx_reg, pidx_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic signed [SUM_WIDTH-1:0] sum_reg [3];
    logic signed [SUM_WIDTH-1:0] sum_next [3];
    logic [15:0] duty_reg [3];
    logic [15:0] duty_next [3];
    logic [2:0] mask_reg, mask_next;
    verdict_t verdict_reg, verdict_next;
    logic done_reg, done_next;
    logic oc_reg, oc_next;
    logic [6:0] codes [NUM_PATTERNS];
    logic [6:0] code_w;
    logic code_we;

    logic [COUNT_WIDTH-1:0] n_eff, tick_inc;
    logic [SAMPLE_WIDTH:0] abs_ia, abs_ib;
    logic [1:0] judged;
    logic cls_start;
    logic cls_done;

    assign n_eff    = (probe_reg == '0) ? COUNT_WIDTH'(1) : probe_reg;
    assign tick_inc = tick_reg + 1'b1;
    assign abs_ia = s_data.curr_a[SAMPLE_WIDTH-1] ? -(SAMPLE_WIDTH+1)'(s_data.curr_a)
                                                  : (SAMPLE_WIDTH+1)'(s_data.curr_a);
    assign abs_ib = s_data.curr_b[SAMPLE_WIDTH-1] ? -(SAMPLE_WIDTH+1)'(s_data.curr_b)
                                                  : (SAMPLE_WIDTH+1)'(s_data.curr_b);

    ipst_classify u_cls (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cls_start),
        .sum_a   (sum_reg[0]),
        .sum_b   (sum_reg[1]),
        .sum_c   (sum_reg[2]),
        .n       (n_eff),
        .supply  (supply_reg),
        .vtol    (vtol_reg),
        .done    (cls_done),
        .code    (code_w)
    );

    always_comb begin
        if (codes[0] == 7'd0 && codes[1] == 7'd7 && codes[2] == 7'd0 && codes[3] == 7'd7
            && codes[4] == 7'd0 && codes[5] == 7'd7 && codes[6] == 7'd0)
            judged = VERDICT_OK;
        else if (codes[0] == 7'd0 && codes[1][0] && !codes[2][0] && codes[3][1]
                 && !codes[4][1] && codes[5][2] && !codes[6][2])
            judged = VERDICT_NO_MOTOR;
        else
            judged = VERDICT_FAULT;
    end

    // Next-state logic of the transaction sequencer.
    always_comb begin
        ctrl_next = ctrl_reg;
        unique case (ctrl_reg)
            ST_ACCEPT: if (s_valid) begin
                if (!s_data.kind && mode_reg == MODE_TEST && phase_reg == PH_CLASS)
                    ctrl_next = ST_CLASS;
                else
                    ctrl_next = ST_OUTPUT;
            end
            ST_CLASS:  if (cls_done) ctrl_next = ST_OUTPUT;
            ST_OUTPUT: if (m_ready) ctrl_next = ST_ACCEPT;
            default:   ctrl_next = ST_ACCEPT;
        endcase
    end

    // Datapath update of the test state for one accepted tick or a finished classification.
    always_comb begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        pidx_next    = pidx_reg;
        tick_next    = tick_reg;
        sum_next     = sum_reg;
        duty_next    = duty_reg;
        mask_next    = mask_reg;
        verdict_next = verdict_reg;
        done_next    = done_reg;
        oc_next      = oc_reg;
        code_we      = 1'b0;
        cls_start    = 1'b0;
        s_ready      = (ctrl_reg == ST_ACCEPT);
        m_valid      = (ctrl_reg == ST_OUTPUT);

        if (ctrl_reg == ST_ACCEPT && s_valid) begin
            done_next = 1'b0;
            oc_next = (abs_ia > (SAMPLE_WIDTH+1)'(ctol_reg))
                   || (abs_ib > (SAMPLE_WIDTH+1)'(ctol_reg));
            if (s_data.kind) begin
                if (mode_reg == MODE_IDLE) begin
                    mode_next  = MODE_TEST;
                    phase_next = PH_START;
                end
            end else if (mode_reg == MODE_TEST) begin
                unique case (phase_reg)
                    PH_START: begin
                        pidx_next  = '0;
                        phase_next = PH_DRIVE;
                    end
                    PH_DRIVE: begin
                        duty_next[0] = (pidx_reg == 3'd1) ? full_duty_reg : 16'd0;
                        duty_next[1] = (pidx_reg == 3'd3) ? full_duty_reg : 16'd0;
                        duty_next[2] = (pidx_reg == 3'd5) ? full_duty_reg : 16'd0;
                        mask_next  = pat_mask(pidx_reg);
                        tick_next  = '0;
                        phase_next = PH_SETTLE;
                    end
                    PH_SETTLE: begin
                        tick_next = tick_inc;
                        if (tick_inc >= skip_reg) begin
                            sum_next[0] = '0;
                            sum_next[1] = '0;
                            sum_next[2] = '0;
                            tick_next   = '0;
                            phase_next  = PH_PROBE;
                        end
                    end
                    PH_PROBE: begin
                        sum_next[0] = sum_reg[0] + SUM_WIDTH'(s_data.volt_a);
                        sum_next[1] = sum_reg[1] + SUM_WIDTH'(s_data.volt_b);
                        sum_next[2] = sum_reg[2] + SUM_WIDTH'(s_data.volt_c);
                        tick_next = tick_inc;
                        if (tick_inc >= n_eff) phase_next = PH_CLASS;
                    end
                    PH_CLASS: cls_start = 1'b1;
                    default: begin
                        verdict_next = verdict_t'(judged);
                        done_next    = 1'b1;
                        mode_next    = MODE_HALT;
                        phase_next   = PH_START;
                    end
                endcase
            end else if (mode_reg == MODE_HALT) begin
                if (phase_reg == PH_START) begin
                    duty_next[0] = '0;
                    duty_next[1] = '0;
                    duty_next[2] = '0;
                    mask_next    = 3'd7;
                    phase_next   = PH_DRIVE;
                    tick_next    = COUNT_WIDTH'(1);
                    if (COUNT_WIDTH'(1) >= skip_reg) begin
                        mode_next  = MODE_IDLE;
                        phase_next = PH_START;
                    end
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc >= skip_reg) begin
                        mode_next  = MODE_IDLE;
                        phase_next = PH_START;
                    end
                end
            end
            // Over-current only applies on a test tick and overrides the step.
            if (!s_data.kind && mode_reg == MODE_TEST && oc_next
                && phase_reg != PH_CLASS) begin
                verdict_next = VERDICT_OVERCURR;
                done_next    = 1'b1;
                mode_next    = MODE_HALT;
                phase_next   = PH_START;
            end
        end

        if (ctrl_reg == ST_CLASS && cls_done) begin
            code_we = 1'b1;
            if (pidx_reg < 3'd6) begin
                pidx_next  = pidx_reg + 1'b1;
                phase_next = PH_DRIVE;
            end else begin
                phase_next = PH_JUDGE;
            end
            if (oc_reg) begin
                verdict_next = VERDICT_OVERCURR;
                done_next    = 1'b1;
                mode_next    = MODE_HALT;
                phase_next   = PH_START;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= ST_ACCEPT;
            mode_reg    <= MODE_IDLE;
            phase_reg   <= PH_START;
            pidx_reg    <= '0;
            tick_reg    <= '0;
            mask_reg    <= 3'd7;
            verdict_reg <= VERDICT_OK;
            done_reg    <= 1'b0;
            oc_reg      <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                duty_reg[k] <= '0;
                sum_reg[k]  <= '0;
            end
        end else begin
            ctrl_reg    <= ctrl_next;
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            pidx_reg    <= pidx_next;
            tick_reg    <= tick_next;
            mask_reg    <= mask_next;
            verdict_reg <= verdict_next;
            done_reg    <= done_next;
            oc_reg      <= oc_next;
            duty_reg    <= duty_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (code_we) codes[pidx_reg] <= code_w;
    end

    always_comb begin
        m_data.duty_a     = duty_reg[0];
        m_data.duty_b     = duty_reg[1];
        m_data.duty_c     = duty_reg[2];
        m_data.float_mask = mask_reg;
        m_data.busy_res   = (mode_reg != MODE_IDLE);
        m_data.done_res   = done_reg;
        m_data.verdict    = verdict_reg;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import ipst_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = REG_SKIP;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

    inverter_power_stage_self_test DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Model of the self-test sequencer and its register copies.
    logic [23:0] skip_ticks, probe_ticks;
    logic [14:0] supply_v, volt_tol, curr_tol;
    logic [15:0] full_duty;
    mode_t       mode;
    phase_t      step_ph;
    logic [2:0]  pat_idx;
    logic [23:0] tick_cnt;
    longint      volt_sum [3];
    logic [6:0]  pat_code [7];
    logic [15:0] duty_q [3];
    logic [2:0]  mask_q;
    verdict_t    verdict_q;

    in_item_t  pending_items[$];
    out_item_t expected_outs[$];
    int        errors = 0;
    int        items_pushed = 0;
    bit        quiet = 1'b0;

    function automatic logic [6:0] level_code(longint sum, longint n, int b);
        longint band;
        longint d;
        band = longint'(volt_tol) * n;
        d = sum - longint'(supply_v) * n;
        if (d < 0) d = -d;
        if (d < band) return 7'(1 << b);
        d = (sum < 0) ? -sum : sum;
        if (d < band) return 7'd0;
        return 7'(16 << b);
    endfunction

    function automatic verdict_t judge_codes();
        if (pat_code[0] == 0 && pat_code[1] == 7 && pat_code[2] == 0 && pat_code[3] == 7
            && pat_code[4] == 0 && pat_code[5] == 7 && pat_code[6] == 0)
            return VERDICT_OK;
        if (pat_code[0] == 0 && pat_code[1][0] && !pat_code[2][0] && pat_code[3][1]
            && !pat_code[4][1] && pat_code[5][2] && !pat_code[6][2])
            return VERDICT_NO_MOTOR;
        return VERDICT_FAULT;
    endfunction

    function automatic out_item_t stage_step(in_item_t x);
        out_item_t o;
        logic done;
        longint n;
        longint ca, cb;
        done = 1'b0;
        n = (probe_ticks == 0) ? 1 : longint'(probe_ticks);
        if (x.kind) begin
            if (mode == MODE_IDLE) begin
                mode = MODE_TEST;
                step_ph = PH_START;
            end
        end else if (mode == MODE_TEST) begin
            case (step_ph)
                PH_START: begin
                    pat_idx = 0;
                    step_ph = PH_DRIVE;
                end
                PH_DRIVE: begin
                    for (int k = 0; k < 3; k++)
                        duty_q[k] = (pat_idx != 0 && pat_idx[0] && (pat_idx >> 1) == k)
                                    ? full_duty : 16'd0;
                    mask_q = pat_mask(pat_idx);
                    tick_cnt = 0;
                    step_ph = PH_SETTLE;
                end
                PH_SETTLE: begin
                    tick_cnt = tick_cnt + 1;
                    if (tick_cnt >= skip_ticks) begin
                        for (int k = 0; k < 3; k++) volt_sum[k] = 0;
                        tick_cnt = 0;
                        step_ph = PH_PROBE;
                    end
                end
                PH_PROBE: begin
                    volt_sum[0] += longint'($signed(x.volt_a));
                    volt_sum[1] += longint'($signed(x.volt_b));
                    volt_sum[2] += longint'($signed(x.volt_c));
                    tick_cnt = tick_cnt + 1;
                    if (longint'(tick_cnt) >= n) step_ph = PH_CLASS;
                end
                PH_CLASS: begin
                    pat_code[pat_idx] = level_code(volt_sum[0], n, 0)
                                      | level_code(volt_sum[1], n, 1)
                                      | level_code(volt_sum[2], n, 2);
                    if (pat_idx < 6) begin
                        pat_idx = pat_idx + 1;
                        step_ph = PH_DRIVE;
                    end else begin
                        step_ph = PH_JUDGE;
                    end
                end
                default: begin
                    verdict_q = judge_codes();
                    done = 1'b1;
                    mode = MODE_HALT;
                    step_ph = PH_START;
                end
            endcase
            ca = longint'($signed(x.curr_a));
            cb = longint'($signed(x.curr_b));
            if (ca < 0) ca = -ca;
            if (cb < 0) cb = -cb;
            if (ca > longint'(curr_tol) || cb > longint'(curr_tol)) begin
                verdict_q = VERDICT_OVERCURR;
                done = 1'b1;
                mode = MODE_HALT;
                step_ph = PH_START;
            end
        end else if (mode == MODE_HALT) begin
            if (step_ph == PH_START) begin
                for (int k = 0; k < 3; k++) duty_q[k] = 16'd0;
                mask_q = 3'd7;
                tick_cnt = 0;
                step_ph = PH_DRIVE;
            end
            tick_cnt = tick_cnt + 1;
            if (tick_cnt >= skip_ticks) begin
                mode = MODE_IDLE;
                step_ph = PH_START;
            end
        end
        o.duty_a = duty_q[0];
        o.duty_b = duty_q[1];
        o.duty_c = duty_q[2];
        o.float_mask = mask_q;
        o.busy_res = (mode != MODE_IDLE);
        o.done_res = done;
        o.verdict = verdict_q;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: one transaction from the pending queue, with random gaps.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_outs.push_back(stage_step(s_data));
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison.
    int recv_stall = 0;
    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap();
            end
            if (m_valid && m_ready) begin
                if (expected_outs.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual %h", $time, m_data);
                end else begin
                    e = expected_outs.pop_front();
                    if (m_data.duty_a !== e.duty_a || m_data.duty_b !== e.duty_b
                        || m_data.duty_c !== e.duty_c || m_data.float_mask !== e.float_mask
                        || m_data.busy_res !== e.busy_res || m_data.done_res !== e.done_res
                        || m_data.verdict !== e.verdict) begin
                        errors++;
                        $display("%0t: mismatch expected duty %h %h %h mask %h busy %b done %b verdict %0d",
                                 $time, e.duty_a, e.duty_b, e.duty_c, e.float_mask,
                                 e.busy_res, e.done_res, e.verdict);
                        $display("%0t:          actual duty %h %h %h mask %h busy %b done %b verdict %0d",
                                 $time, m_data.duty_a, m_data.duty_b, m_data.duty_c,
                                 m_data.float_mask, m_data.busy_res, m_data.done_res,
                                 m_data.verdict);
                    end
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (!s_valid && pending_items.size() == 0 && expected_outs.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_reg(logic [CFG_ADDR_WIDTH-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[23:0];
        case (idx)
            REG_SKIP:   skip_ticks = val[23:0];
            REG_PROBE:  probe_ticks = val[23:0];
            REG_SUPPLY: supply_v = val[14:0];
            REG_VTOL:   volt_tol = val[14:0];
            REG_CTOL:   curr_tol = val[14:0];
            default:    full_duty = val[15:0];
        endcase
    endtask

    task automatic configure(int unsigned sk, int unsigned pr, int unsigned sv,
                             int unsigned vt, int unsigned ct, int unsigned fd);
        set_reg(REG_SKIP, sk);
        set_reg(REG_PROBE, pr);
        set_reg(REG_SUPPLY, sv);
        set_reg(REG_VTOL, vt);
        set_reg(REG_CTOL, ct);
        set_reg(REG_DUTY, fd);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits for the block to drain, including the classifier tail.
    task automatic drain();
        wait (pending_items.size() == 0 && !s_valid && expected_outs.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_curr();
        int unsigned m;
        m = $urandom_range(0, curr_tol);
        return $urandom_range(0, 1) ? 16'(-int'(m)) : 16'(m);
    endfunction

    function automatic logic [15:0] over_curr();
        int unsigned m;
        m = $urandom_range(int'(curr_tol) + 1, 32768);
        if (m == 32768 || $urandom_range(0, 1)) return 16'(-int'(m));
        return 16'(m);
    endfunction

    function automatic logic [15:0] near(int level);
        int noise;
        noise = (volt_tol == 0) ? 0 : $urandom_range(0, 2 * (volt_tol - 1)) - (volt_tol - 1);
        return 16'(level + noise);
    endfunction

    task automatic push_item(logic k, logic [15:0] va, logic [15:0] vb, logic [15:0] vc,
                             logic [15:0] ia, logic [15:0] ib);
        in_item_t t;
        t.kind = k;
        t.volt_a = va;
        t.volt_b = vb;
        t.volt_c = vc;
        t.curr_a = ia;
        t.curr_b = ib;
        pending_items.push_back(t);
        items_pushed++;
    endtask

    task automatic push_noise(int cnt);
        repeat (cnt) push_item(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                               rand_curr(), rand_curr());
    endtask

    // One full self-test run. Flavor: 0 healthy, 1 no motor, 2 faulty stage, 3 over-current.
    task automatic run_test(int flavor);
        int skip_eff, n, tick_no, abort_at, total;
        logic [15:0] v [3];
        logic [15:0] ia, ib;
        skip_eff = (skip_ticks == 0) ? 1 : int'(skip_ticks);
        n = (probe_ticks == 0) ? 1 : int'(probe_ticks);
        if (n > 40) n = 40;
        total = 2 + 7 * (skip_eff + n + 2);
        abort_at = (flavor == 3) ? $urandom_range(0, total - 1) : -1;
        tick_no = 0;
        push_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        for (int p = -1; p <= 7; p++) begin
            int len;
            len = (p < 0 || p == 7) ? 1 : skip_eff + n + 2;
            for (int j = 0; j < len; j++) begin
                bit probing;
                probing = (p >= 0 && p < 7 && j > skip_eff && j <= skip_eff + n);
                for (int k = 0; k < 3; k++) begin
                    bit hi;
                    hi = (p % 2 == 1);
                    if (!probing || flavor == 2 || flavor == 3 && $urandom_range(0, 1))
                        v[k] = 16'($urandom);
                    else if (flavor == 1 && p > 0 && (p - 1) / 2 != k)
                        v[k] = 16'($urandom);
                    else
                        v[k] = hi ? near(int'(supply_v)) : near(0);
                end
                ia = rand_curr();
                ib = rand_curr();
                if (tick_no == abort_at) begin
                    case ($urandom_range(0, 2))
                        0: ia = over_curr();
                        1: ib = over_curr();
                        default: begin ia = over_curr(); ib = over_curr(); end
                    endcase
                end
                push_item(1'b0, v[0], v[1], v[2], ia, ib);
                if ($urandom_range(0, 19) == 0)
                    push_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                if (tick_no == abort_at) begin
                    push_noise(skip_eff + 1);
                    return;
                end
                tick_no++;
            end
        end
        push_noise(skip_eff);
    endtask

    initial begin
        skip_ticks = 24'd1000; probe_ticks = 24'd4000; supply_v = 15'd12000;
        volt_tol = 15'd1000; curr_tol = 15'd20000; full_duty = 16'd2000;
        mode = MODE_IDLE; step_ph = PH_START; pat_idx = 0; tick_cnt = 0;
        for (int k = 0; k < 3; k++) begin volt_sum[k] = 0; duty_q[k] = 0; end
        for (int k = 0; k < 7; k++) pat_code[k] = 0;
        mask_q = 3'd7;
        verdict_q = VERDICT_OK;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Idle ticks with extreme samples have no effect, not even over-current.
        push_item(1'b0, 16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff);
        push_item(1'b0, 16'h8000, 16'h7fff, 16'hffff, 16'h7fff, 16'h8000);
        drain();
        configure(1, 1, 12000, 1000, 20000, 2000);
        run_test(0);
        drain();
        configure(0, 0, 15000, 2000, 32767, 65535);
        run_test(1);
        drain();
        configure(2, 3, 32767, 0, 0, 0);
        run_test(2);
        drain();
        // Longest probe window, ended early by an over-current abort.
        configure(1, 16777215, 0, 32767, 100, 1);
        push_item(1'b1, 0, 0, 0, 0, 0);
        push_noise(20);
        push_item(1'b0, 0, 0, 0, 16'h8000, 0);
        push_noise(3);
        drain();
        // Longest settle time, only idle ticks while it is set.
        configure(16777215, 2, 12000, 1000, 20000, 2000);
        push_noise(3);
        drain();

        while (items_pushed < 900) begin
            int sk, pr, fl;
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: sk = 0;
                1: sk = 1;
                default: sk = $urandom_range(2, 5);
            endcase
            case ($urandom_range(0, 3))
                0: pr = 0;
                1: pr = 1;
                default: pr = $urandom_range(2, 6);
            endcase
            configure(sk, pr, $urandom_range(4000, 28000),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 32767)
                                                : $urandom_range(1, 3000),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 32767)
                                                : $urandom_range(1000, 30000),
                      $urandom_range(0, 65535));
            repeat ($urandom_range(1, 3)) begin
                fl = $urandom_range(0, 9);
                run_test(fl < 4 ? 0 : fl < 6 ? 1 : fl < 8 ? 2 : 3);
                if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 3));
            end
            drain();
        end

        if (errors == 0 && expected_outs.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
